// ----- hdl/itbd_pkg.sv -----
// Shared types and constants for the integer to base digits unit.
`default_nettype none

package itbd_pkg;

  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned BaseWidth    = 6;
  localparam int unsigned SizeWidth    = 7;
  localparam int unsigned CharWidth    = 8;
  localparam int unsigned PosWidth     = 6;
  localparam int unsigned StatusWidth  = 2;

  localparam logic [BaseWidth-1:0] BaseMin = 6'd2;
  localparam logic [BaseWidth-1:0] BaseMax = 6'd36;

  localparam logic [CharWidth-1:0] CharNul   = 8'h00;
  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharUpA   = 8'h41;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2D;
  localparam logic [BaseWidth-1:0] DigitTen  = 6'd10;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK      = 2'd0,
    ST_NOSIZE  = 2'd1,
    ST_BADBASE = 2'd2
  } status_e;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [BaseWidth-1:0]  base;
    logic                  is_signed;
    logic [SizeWidth-1:0]  buffer_size;
  } in_t;

  typedef struct packed {
    logic [CharWidth-1:0]   character;
    logic [PosWidth-1:0]    position;
    logic                   last;
    logic [StatusWidth-1:0] status;
  } out_t;

endpackage

`default_nettype wire

// ----- hdl/integer_to_base_digits_unit.sv -----
// Integer to ASCII text conversion in a radix from 2 to 36, one character per output beat.
//
// Each input beat yields a run of output beats: the terminating NUL at the last
// buffer position, then the digits least significant first at falling positions,
// then a minus sign for a negative signed value if the buffer has room, with last
// set on the final beat. Digits come from a bit-serial restoring divider that
// retires one quotient bit per cycle. Error results take one beat. One item is
// converted at a time; input stall is high until the final beat of the current
// item has been taken.
`default_nettype none

module integer_to_base_digits_unit #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_BUFFER = 64
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire itbd_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output itbd_pkg::out_t      out_data_o
);
  import itbd_pkg::*;

  localparam int unsigned CntWidth = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  out_t                    out_q, out_d;
  logic [VALUE_BITS-1:0]   quot_q, quot_d;
  logic [BaseWidth-1:0]    rem_q, rem_d;
  logic [BaseWidth-1:0]    base_q, base_d;
  logic [CntWidth-1:0]     cnt_q, cnt_d;
  logic [PosWidth-1:0]     pos_q, pos_d;
  logic [PosWidth-1:0]     room_q, room_d;
  logic                    neg_q, neg_d;
  logic                    done_q, done_d;
  logic                    sign_next_q, sign_next_d;

  logic                    in_acc, out_acc;
  logic [SizeWidth-1:0]    size_clamp;
  logic [PosWidth-1:0]     pos_init;
  logic [VALUE_BITS-1:0]   v_in;
  logic                    v_neg;
  logic [BaseWidth:0]      trial;
  logic                    ge;
  logic [BaseWidth-1:0]    rem_step;
  logic [VALUE_BITS-1:0]   quot_step;
  logic [PosWidth-1:0]     room_next;
  logic                    digit_last;
  logic [CharWidth-1:0]    digit_char;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  assign size_clamp = (in_data_i.buffer_size > SizeWidth'(MAX_BUFFER)) ?
                      SizeWidth'(MAX_BUFFER) : in_data_i.buffer_size;
  assign pos_init   = PosWidth'(size_clamp - 7'd1);
  assign v_in       = VALUE_BITS'(in_data_i.value);
  assign v_neg      = in_data_i.is_signed && v_in[VALUE_BITS-1];

  assign trial     = {rem_q, quot_q[VALUE_BITS-1]};
  assign ge        = (trial >= {1'b0, base_q});
  assign rem_step  = ge ? BaseWidth'(trial - {1'b0, base_q}) : trial[BaseWidth-1:0];
  assign quot_step = {quot_q[VALUE_BITS-2:0], ge};
  assign room_next = room_q - 6'd1;
  assign digit_last = (room_next == '0) || ((quot_step == '0) && !neg_q);
  assign digit_char = (rem_step < DigitTen) ? (CharZero + CharWidth'(rem_step)) :
                      (CharUpA + CharWidth'(rem_step - DigitTen));

  always_comb begin
    state_d     = state_q;
    out_d       = out_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    room_d      = room_q;
    neg_d       = neg_q;
    done_d      = done_q;
    sign_next_d = sign_next_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d     = S_OUT;
          sign_next_d = 1'b0;
          out_d.character = CharNul;
          out_d.position  = '0;
          out_d.last      = 1'b1;
          done_d          = 1'b1;
          if (in_data_i.buffer_size == '0) begin
            out_d.status = ST_NOSIZE;
          end else if ((in_data_i.base < BaseMin) || (in_data_i.base > BaseMax)) begin
            out_d.status = ST_BADBASE;
          end else begin
            out_d.status   = ST_OK;
            out_d.position = pos_init;
            out_d.last     = (pos_init == '0);
            done_d         = (pos_init == '0);
            pos_d          = pos_init;
            room_d         = pos_init;
            neg_d          = v_neg;
            quot_d         = v_neg ? (-v_in) : v_in;
            base_d         = in_data_i.base;
          end
        end
      end
      S_DIV: begin
        quot_d = quot_step;
        rem_d  = rem_step;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d         = S_OUT;
          pos_d           = pos_q - 6'd1;
          room_d          = room_next;
          out_d.character = digit_char;
          out_d.position  = pos_q - 6'd1;
          out_d.last      = digit_last;
          out_d.status    = ST_OK;
          done_d          = digit_last;
          sign_next_d     = !digit_last && (quot_step == '0);
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (done_q) begin
            state_d = S_IDLE;
          end else if (sign_next_q) begin
            pos_d           = pos_q - 6'd1;
            room_d          = room_next;
            out_d.character = CharMinus;
            out_d.position  = pos_q - 6'd1;
            out_d.last      = 1'b1;
            out_d.status    = ST_OK;
            done_d          = 1'b1;
            sign_next_d     = 1'b0;
          end else begin
            state_d = S_DIV;
            rem_d   = '0;
            cnt_d   = CntWidth'(VALUE_BITS - 1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      sign_next_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      sign_next_q <= sign_next_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    base_q <= base_d;
    cnt_q  <= cnt_d;
    pos_q  <= pos_d;
    room_q <= room_d;
    neg_q  <= neg_d;
  end

  // The partial remainder always stays below the divisor.
  a_rem_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && (cnt_q != CntWidth'(VALUE_BITS - 1)) |-> (rem_q < base_q))
    else $error("remainder not below base");

  // An error beat is always the only and final beat of its item.
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_q.status != ST_OK) |-> out_q.last)
    else $error("error beat without last");

  // A beat that is not final leaves room in the buffer for another character.
  a_room_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_q.last |-> (room_q != '0))
    else $error("non-final beat with full buffer");

  // The final beat returns the unit to idle once it is taken.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_q.last |=> (state_q == S_IDLE))
    else $error("unit busy after final beat");

endmodule

`default_nettype wire

// ----- tb/sv/itbd_text_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts the character beats of each converted number and compares them.
module itbd_text_checker #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_BUFFER = 64
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  input  wire             in_stall_i,
  input  itbd_pkg::in_t   in_data_i,
  input  wire             out_valid_i,
  input  wire             out_stall_i,
  input  itbd_pkg::out_t  out_data_i,
  output int unsigned     mismatches_o,
  output int unsigned     chars_pending_o
);
  import itbd_pkg::*;

  out_t        pending_chars[$];
  out_t        want;
  int unsigned mismatch_total;

  function automatic out_t make_char(logic [CharWidth-1:0] ch, logic [PosWidth-1:0] pos,
                                     status_e status);
    out_t beat;
    beat.character = ch;
    beat.position  = pos;
    beat.last      = 1'b0;
    beat.status    = status;
    return beat;
  endfunction

  function automatic void predict_text(in_t num);
    logic [VALUE_BITS-1:0] mag;
    logic [BaseWidth-1:0]  digit;
    logic [PosWidth-1:0]   pos;
    int unsigned           room;
    logic                  negative;
    out_t                  beat;
    if (num.buffer_size == '0) begin
      beat = make_char(CharNul, '0, ST_NOSIZE);
      beat.last = 1'b1;
      pending_chars.push_back(beat);
      return;
    end
    if (num.base < BaseMin || num.base > BaseMax) begin
      beat = make_char(CharNul, '0, ST_BADBASE);
      beat.last = 1'b1;
      pending_chars.push_back(beat);
      return;
    end
    room = (num.buffer_size > MAX_BUFFER) ? MAX_BUFFER - 1 : num.buffer_size - 1;
    pos = PosWidth'(room);
    pending_chars.push_back(make_char(CharNul, pos, ST_OK));
    mag = VALUE_BITS'(num.value);
    negative = num.is_signed && mag[VALUE_BITS-1];
    if (negative) mag = -mag;
    do begin
      if (room == 0) break;
      digit = BaseWidth'(mag % num.base);
      mag = mag / num.base;
      pos--;
      room--;
      pending_chars.push_back(make_char((digit < DigitTen) ? CharWidth'(CharZero + digit) :
                                        CharWidth'(CharUpA + (digit - DigitTen)), pos, ST_OK));
    end while (mag != 0);
    if (negative && room != 0) begin
      pos--;
      pending_chars.push_back(make_char(CharMinus, pos, ST_OK));
    end
    beat = pending_chars.pop_back();
    beat.last = 1'b1;
    pending_chars.push_back(beat);
  endfunction

  function automatic bit field_ok(string name, int unsigned exp_val, int unsigned got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatch_total = 0;
      mismatches_o <= 0;
      chars_pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_text(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got char %0h pos %0d last %0b status %0d",
                   $time, out_data_i.character, out_data_i.position, out_data_i.last,
                   out_data_i.status);
          mismatch_total++;
        end else begin
          want = pending_chars.pop_front();
          if (!(field_ok("character", want.character, out_data_i.character) &
                field_ok("position", want.position, out_data_i.position) &
                field_ok("last", want.last, out_data_i.last) &
                field_ok("status", want.status, out_data_i.status))) begin
            mismatch_total++;
          end
        end
      end
      mismatches_o <= mismatch_total;
      chars_pending_o <= pending_chars.size();
    end
  end

endmodule

// ----- tb/sv/tb_integer_to_base_digits_unit.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, number stimulus and the final verdict.
module tb_integer_to_base_digits_unit;
  import itbd_pkg::*;

  localparam int unsigned HalfPeriod    = 5;
  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned RandomNumbers = 380;
  localparam int unsigned CycleLimit    = 2_000_000;
  localparam int unsigned DrainCycles   = 100;
  localparam int unsigned IdlePercent   = 27;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_t         in_data   = '0;
  logic        out_stall = 1'b0;
  logic        calm      = 1'b0;
  logic        in_stall;
  logic        out_valid;
  out_t        out_data;
  int unsigned mismatches;
  int unsigned chars_pending;
  int unsigned cycles    = 0;

  always #HalfPeriod clk = ~clk;

  integer_to_base_digits_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  itbd_text_checker text_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .mismatches_o    (mismatches),
    .chars_pending_o (chars_pending)
  );

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IdlePercent);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_t make_number(logic [ValueWidth-1:0] value, int unsigned base, bit sgn,
                                      int unsigned size);
    in_t num;
    num.value       = value;
    num.base        = BaseWidth'(base);
    num.is_signed   = sgn;
    num.buffer_size = SizeWidth'(size);
    return num;
  endfunction

  function automatic in_t random_number();
    in_t         num;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      case ($urandom_range(2))
        0:       num.base = '0;
        1:       num.base = BaseWidth'(1);
        default: num.base = BaseWidth'($urandom_range(63, 37));
      endcase
    end else if (pick < 16) begin
      case ($urandom_range(3))
        0:       num.base = BaseMin;
        1:       num.base = BaseMax;
        2:       num.base = BaseWidth'(10);
        default: num.base = BaseWidth'(16);
      endcase
    end else begin
      num.base = BaseWidth'($urandom_range(36, 2));
    end
    pick = $urandom_range(99);
    if (pick < 4)       num.buffer_size = '0;
    else if (pick < 12) num.buffer_size = SizeWidth'($urandom_range(127, 65));
    else if (pick < 40) num.buffer_size = SizeWidth'($urandom_range(8, 1));
    else                num.buffer_size = SizeWidth'($urandom_range(64, 9));
    pick = $urandom_range(99);
    if (pick < 15) begin
      num.value = $urandom_range(40, 0);
    end else if (pick < 25) begin
      case ($urandom_range(3))
        0:       num.value = 32'h8000_0000;
        1:       num.value = 32'hFFFF_FFFF;
        2:       num.value = 32'h7FFF_FFFF;
        default: num.value = '0;
      endcase
    end else if (pick < 35) begin
      num.value = -($urandom_range(1000, 1));
    end else begin
      num.value = $urandom;
    end
    num.is_signed = 1'($urandom_range(1));
    return num;
  endfunction

  task automatic send_number(in_t num);
    if (!calm && $urandom_range(99) < IdlePercent) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat ($urandom_range(5, 0)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= num;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (chars_pending != 0);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    send_number(make_number(32'd0, 10, 1'b0, 64));
    send_number(make_number(32'd55, 0, 1'b0, 0));
    send_number(make_number(32'd55, 10, 1'b1, 0));
    send_number(make_number(32'd55, 0, 1'b0, 10));
    send_number(make_number(32'd55, 1, 1'b0, 10));
    send_number(make_number(32'd55, 37, 1'b1, 10));
    send_number(make_number(32'd55, 63, 1'b0, 127));
    send_number(make_number(32'hFFFF_FFFF, 2, 1'b0, 64));
    send_number(make_number(32'h8000_0000, 2, 1'b1, 64));
    send_number(make_number(32'h8000_0000, 10, 1'b1, 127));
    send_number(make_number(32'hFFFF_FFFF, 10, 1'b1, 12));
    send_number(make_number(32'hFFFF_FFFF, 36, 1'b0, 100));
    send_number(make_number(32'h7FFF_FFFF, 16, 1'b1, 64));
    send_number(make_number(32'd123, 10, 1'b0, 1));
    send_number(make_number(32'd12345, 10, 1'b0, 2));
    send_number(make_number(-32'd123, 10, 1'b1, 4));
    send_number(make_number(-32'd123, 10, 1'b1, 5));
    send_number(make_number(32'd34, 35, 1'b0, 8));
    send_number(make_number(32'd35, 36, 1'b0, 8));
    send_number(make_number(32'd10, 11, 1'b1, 8));
    send_number(make_number(32'd0, 2, 1'b1, 2));
    send_number(make_number(32'hDEAD_BEEF, 36, 1'b1, 65));
    send_number(make_number(32'hFFFF_FFFF, 2, 1'b0, 127));
    @(negedge clk) in_valid <= 1'b0;
    wait_drained();

    for (int unsigned i = 0; i < RandomNumbers; i++) begin
      calm <= (i >= 120 && i < 180);
      if (i == 250) begin
        @(negedge clk) in_valid <= 1'b0;
        wait_drained();
      end
      send_number(random_number());
    end
    @(negedge clk);
    in_valid <= 1'b0;
    calm     <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
